// ===== sv/rcdm_pkg.sv =====
// Shared types and constants for the differential drive mixer.
// No dependencies; imported by every module of the block.
package rcdm_pkg;

  localparam int RAW_W   = 11;
  localparam int Q14_W   = 16;
  localparam int SCALE_W = 15;
  localparam int MAG_W   = 15;
  localparam int MIX_W   = 17;
  localparam int DENOM_W = 16;
  localparam int PROD_W  = 30;
  localparam int QUO_W   = 15;

  localparam logic [RAW_W-1:0]   RC_CENTRE = 11'd992;
  localparam logic [9:0]         RC_SPAN   = 10'd819;
  localparam logic [MAG_W-1:0]   Q14_ONE   = 15'd16384;
  // ceil(2^34 / 819): |d| * 2^14 / 819 == (|d| * RECIP_M) >> 20 for |d| <= 819
  localparam logic [24:0]        RECIP_M     = 25'd20976642;
  localparam int                 RECIP_SHIFT = 20;

  typedef enum logic [2:0] {
    CFG_ARM_THR        = 3'd0,
    CFG_SPEED_LOW_THR  = 3'd1,
    CFG_SPEED_HIGH_THR = 3'd2,
    CFG_SLOW_SCALE     = 3'd3,
    CFG_MEDIUM_SCALE   = 3'd4,
    CFG_FAST_SCALE     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SPEED_SLOW   = 2'd0,
    SPEED_MEDIUM = 2'd1,
    SPEED_FAST   = 2'd2
  } speed_mode_e;

  typedef struct packed {
    logic signed [Q14_W-1:0] arm_thr;
    logic signed [Q14_W-1:0] speed_low_thr;
    logic signed [Q14_W-1:0] speed_high_thr;
    logic [SCALE_W-1:0]      slow_scale;
    logic [SCALE_W-1:0]      medium_scale;
    logic [SCALE_W-1:0]      fast_scale;
  } cfg_t;

  // One classified command pair, handed from the front to the back
  typedef struct packed {
    logic signed [MIX_W-1:0] left_mix;
    logic signed [MIX_W-1:0] right_mix;
    logic [SCALE_W-1:0]      scale;
    logic [DENOM_W-1:0]      denom;
    logic                    armed;
    speed_mode_e             mode;
  } mix_item_t;

endpackage

// ===== sv/rc_differential_drive_mixer.sv =====
// Top level of the differential drive mixer: configuration registers, front
// end, queue and back end. Depends on rcdm_pkg, rcdm_front, rcdm_queue, rcdm_back.
//
// Usage
//   Input items arrive on the s_axis group: four raw 11-bit radio channels in
//   tdata and the failsafe flag in tuser. Each item yields exactly one result
//   on the m_axis group: left and right wheel commands (signed Q14) in tdata,
//   armed flag and speed mode in tuser.
//   Configuration is written over the cfg_* channel (index, data); it is
//   always ready and must only be written while no item is in flight.
//   Throughput: one item per clock unless m_axis_tready stalls the back end.
//   Path from acceptance to m_axis_tvalid: the normalise and classify
//   stages, one queue slot, the scaling multiplier, fifteen divider stages
//   (one quotient bit each) and the output register.
//   Stalls: a held m_axis_tready freezes the back end and its output register;
//   the queue then fills, and s_axis_tready falls only once the queue is full
//   and the front stages are occupied. The front keeps taking items until then.
//   Reset: asynchronous, active low; clears every valid flag and the queue and
//   loads the configuration defaults (arm at 0.5, slow below -0.5, fast above
//   0.5, scales 1/3, 2/3 and 1). No clearing pass is needed.
module rc_differential_drive_mixer #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [10:0] throttle_raw, [21:11] steering_raw, [32:22] arm_raw,
  // [43:33] speed_raw, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  // [0] link_lost
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] left_drive, [31:16] right_drive
  output logic [31:0] m_axis_tdata,
  // [0] is_armed, [2:1] speed_mode
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import rcdm_pkg::*;

  localparam cfg_t CfgReset = '{
    arm_thr:        16'sd8192,
    speed_low_thr:  -16'sd8192,
    speed_high_thr: 16'sd8192,
    slow_scale:     15'd5461,
    medium_scale:   15'd10923,
    fast_scale:     15'd16384
  };

  cfg_t                    cfg_q, cfg_d;
  logic                    front_valid, front_ready;
  mix_item_t               front_item;
  logic                    queue_valid, queue_ready;
  mix_item_t               queue_item;
  logic signed [Q14_W-1:0] left_drive, right_drive;
  logic                    is_armed;
  speed_mode_e             speed_mode;

  // Configuration registers; writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ARM_THR:        cfg_d.arm_thr        = $signed(cfg_data_i);
        CFG_SPEED_LOW_THR:  cfg_d.speed_low_thr  = $signed(cfg_data_i);
        CFG_SPEED_HIGH_THR: cfg_d.speed_high_thr = $signed(cfg_data_i);
        CFG_SLOW_SCALE:     cfg_d.slow_scale     = cfg_data_i[SCALE_W-1:0];
        CFG_MEDIUM_SCALE:   cfg_d.medium_scale   = cfg_data_i[SCALE_W-1:0];
        CFG_FAST_SCALE:     cfg_d.fast_scale     = cfg_data_i[SCALE_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: normalise and classify
  rcdm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .throttle_raw_i (s_axis_tdata[10:0]),
    .steering_raw_i (s_axis_tdata[21:11]),
    .arm_raw_i      (s_axis_tdata[32:22]),
    .speed_raw_i    (s_axis_tdata[43:33]),
    .link_lost_i    (s_axis_tuser[0]),
    .cfg_i          (cfg_q),
    .out_valid_o    (front_valid),
    .out_ready_i    (front_ready),
    .out_item_o     (front_item)
  );

  // Queue decouples front stalls from back stalls
  rcdm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_item_o  (queue_item)
  );

  // Back: scale, divide, hold the result
  rcdm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (queue_valid),
    .in_ready_o    (queue_ready),
    .in_item_i     (queue_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .left_drive_o  (left_drive),
    .right_drive_o (right_drive),
    .is_armed_o    (is_armed),
    .speed_mode_o  (speed_mode)
  );

  assign m_axis_tdata = {right_drive, left_drive};
  assign m_axis_tuser = {speed_mode, is_armed};

endmodule

// ===== sv/rcdm_front.sv =====
// Front end: normalises the four raw channels to Q14 and classifies the item
// (arm, speed mode, mix sums, divisor). Depends on rcdm_pkg.
module rcdm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rcdm_pkg::RAW_W-1:0]   throttle_raw_i,
  input  logic [rcdm_pkg::RAW_W-1:0]   steering_raw_i,
  input  logic [rcdm_pkg::RAW_W-1:0]   arm_raw_i,
  input  logic [rcdm_pkg::RAW_W-1:0]   speed_raw_i,
  input  logic                         link_lost_i,
  input  rcdm_pkg::cfg_t               cfg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rcdm_pkg::mix_item_t          out_item_o
);
  import rcdm_pkg::*;

  // Returns {negative, magnitude}; magnitude saturates at one in Q14
  function automatic logic [MAG_W:0] norm_chan(input logic [RAW_W-1:0] raw);
    logic signed [RAW_W:0] d;
    logic [RAW_W-1:0]      a;
    logic [34:0]           p;
    logic [MAG_W-1:0]      m;
    d = $signed({1'b0, raw}) - $signed({1'b0, RC_CENTRE});
    a = d[RAW_W] ? RAW_W'(-d) : RAW_W'(d);
    p = {25'd0, a[9:0]} * {10'd0, RECIP_M};
    if (a > RAW_W'(RC_SPAN)) begin
      m = Q14_ONE;
    end else begin
      m = p[RECIP_SHIFT +: MAG_W];
    end
    return {d[RAW_W], m};
  endfunction

  function automatic logic signed [Q14_W-1:0] to_signed(input logic neg,
                                                        input logic [MAG_W-1:0] mag);
    logic signed [Q14_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  logic                    en1, en2;
  logic                    s1_vld_q, s2_vld_q;
  logic                    s1_lost_q;
  logic [MAG_W-1:0]        s1_mag_q [4];
  logic                    s1_neg_q [4];
  logic [MAG_W:0]          norm [4];
  mix_item_t               s2_item_d, s2_item_q;

  logic signed [Q14_W-1:0] t_q14, s_q14, a_q14, sp_q14;
  logic signed [MIX_W-1:0] l_mix, r_mix;
  logic [MIX_W-1:0]        l_abs, r_abs;
  logic [DENOM_W-1:0]      peak;
  logic [SCALE_W-1:0]      scale_sel;
  logic                    armed;

  assign en2        = !s2_vld_q || out_ready_i;
  assign en1        = !s1_vld_q || en2;
  assign in_ready_o = en1;

  assign norm[0] = norm_chan(throttle_raw_i);
  assign norm[1] = norm_chan(steering_raw_i);
  assign norm[2] = norm_chan(arm_raw_i);
  assign norm[3] = norm_chan(speed_raw_i);

  // Stage one: normalised magnitudes, failsafe drops them to zero
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_lost_q <= link_lost_i;
      for (int c = 0; c < 4; c++) begin
        s1_mag_q[c] <= link_lost_i ? '0 : norm[c][MAG_W-1:0];
        s1_neg_q[c] <= !link_lost_i && norm[c][MAG_W];
      end
    end
  end

  // Stage two: classify
  always_comb begin
    t_q14  = to_signed(s1_neg_q[0], s1_mag_q[0]);
    s_q14  = to_signed(s1_neg_q[1], s1_mag_q[1]);
    a_q14  = to_signed(s1_neg_q[2], s1_mag_q[2]);
    sp_q14 = to_signed(s1_neg_q[3], s1_mag_q[3]);
    armed  = !s1_lost_q && (a_q14 > cfg_i.arm_thr);

    s2_item_d = '0;
    if (sp_q14 < cfg_i.speed_low_thr) begin
      s2_item_d.mode = SPEED_SLOW;
      scale_sel      = cfg_i.slow_scale;
    end else if (sp_q14 > cfg_i.speed_high_thr) begin
      s2_item_d.mode = SPEED_FAST;
      scale_sel      = cfg_i.fast_scale;
    end else begin
      s2_item_d.mode = SPEED_MEDIUM;
      scale_sel      = cfg_i.medium_scale;
    end

    l_mix = {t_q14[Q14_W-1], t_q14} + {s_q14[Q14_W-1], s_q14};
    r_mix = {t_q14[Q14_W-1], t_q14} - {s_q14[Q14_W-1], s_q14};
    l_abs = l_mix[MIX_W-1] ? MIX_W'(-l_mix) : MIX_W'(l_mix);
    r_abs = r_mix[MIX_W-1] ? MIX_W'(-r_mix) : MIX_W'(r_mix);
    peak  = (l_abs > r_abs) ? l_abs[DENOM_W-1:0] : r_abs[DENOM_W-1:0];

    s2_item_d.scale     = (scale_sel > Q14_ONE) ? Q14_ONE : scale_sel;
    s2_item_d.denom     = (peak > DENOM_W'(Q14_ONE)) ? peak : DENOM_W'(Q14_ONE);
    s2_item_d.armed     = armed;
    s2_item_d.left_mix  = armed ? l_mix : '0;
    s2_item_d.right_mix = armed ? r_mix : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_item_q <= s2_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_vld_q <= in_valid_i;
      end
      if (en2) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  assign out_valid_o = s2_vld_q;
  assign out_item_o  = s2_item_q;

endmodule

// ===== sv/rcdm_queue.sv =====
// Short queue between the front and the back of the mixer.
// Depends on rcdm_pkg for the item type.
module rcdm_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rcdm_pkg::mix_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rcdm_pkg::mix_item_t out_item_o
);
  import rcdm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mix_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== sv/rcdm_back.sv =====
// Back end: scales both mix sums, divides them by the shared divisor in a
// one-bit-per-stage pipeline and holds the result. Depends on rcdm_pkg.
module rcdm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rcdm_pkg::mix_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rcdm_pkg::Q14_W-1:0] left_drive_o,
  output logic signed [rcdm_pkg::Q14_W-1:0] right_drive_o,
  output logic                              is_armed_o,
  output rcdm_pkg::speed_mode_e             speed_mode_o
);
  import rcdm_pkg::*;

  logic                    en;
  logic [QUO_W:0]          vld_q;
  logic                    out_vld_q;

  // Lane 0 carries the left sum, lane 1 the right sum
  logic [PROD_W-1:0]       rem_q [0:1][0:QUO_W];
  logic [QUO_W-1:0]        quo_q [0:1][0:QUO_W];
  logic                    neg_q [0:1][0:QUO_W];
  logic [DENOM_W-1:0]      denom_q [0:QUO_W];
  logic                    armed_q [0:QUO_W];
  speed_mode_e             mode_q [0:QUO_W];

  logic [PROD_W-1:0]       dsh [1:QUO_W];
  logic                    ge [0:1][1:QUO_W];
  logic [PROD_W-1:0]       rem_d [0:1][1:QUO_W];
  logic [QUO_W-1:0]        quo_d [0:1][1:QUO_W];

  logic signed [MIX_W-1:0] mix_in [0:1];
  logic [MIX_W-1:0]        mix_abs [0:1];
  logic [PROD_W-1:0]       prod [0:1];
  logic signed [Q14_W-1:0] drive_d [0:1];
  logic signed [Q14_W-1:0] drive_q [0:1];
  logic                    armed_out_q;
  speed_mode_e             mode_out_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Entry stage: magnitude times scale, one multiplier per lane
  always_comb begin
    mix_in[0] = in_item_i.left_mix;
    mix_in[1] = in_item_i.right_mix;
    for (int j = 0; j < 2; j++) begin
      mix_abs[j] = mix_in[j][MIX_W-1] ? MIX_W'(-mix_in[j]) : MIX_W'(mix_in[j]);
      prod[j]    = {14'd0, mix_abs[j][DENOM_W-1:0]} * {15'd0, in_item_i.scale};
    end
  end

  // Divider stages: stage k settles quotient bit QUO_W-k, MSB first
  always_comb begin
    for (int k = 1; k <= QUO_W; k++) begin
      dsh[k] = PROD_W'(denom_q[k-1]) << (QUO_W - k);
      for (int j = 0; j < 2; j++) begin
        ge[j][k]    = rem_q[j][k-1] >= dsh[k];
        rem_d[j][k] = ge[j][k] ? rem_q[j][k-1] - dsh[k] : rem_q[j][k-1];
        quo_d[j][k] = {quo_q[j][k-1][QUO_W-2:0], ge[j][k]};
      end
    end
    for (int j = 0; j < 2; j++) begin
      drive_d[j] = neg_q[j][QUO_W] ? -$signed({1'b0, quo_q[j][QUO_W]})
                                   : $signed({1'b0, quo_q[j][QUO_W]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        rem_q[j][0] <= prod[j];
        quo_q[j][0] <= '0;
        neg_q[j][0] <= mix_in[j][MIX_W-1];
      end
      denom_q[0] <= in_item_i.denom;
      armed_q[0] <= in_item_i.armed;
      mode_q[0]  <= in_item_i.mode;
      for (int k = 1; k <= QUO_W; k++) begin
        for (int j = 0; j < 2; j++) begin
          rem_q[j][k] <= rem_d[j][k];
          quo_q[j][k] <= quo_d[j][k];
          neg_q[j][k] <= neg_q[j][k-1];
        end
        denom_q[k] <= denom_q[k-1];
        armed_q[k] <= armed_q[k-1];
        mode_q[k]  <= mode_q[k-1];
      end
      drive_q[0]  <= drive_d[0];
      drive_q[1]  <= drive_d[1];
      armed_out_q <= armed_q[QUO_W];
      mode_out_q  <= mode_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[QUO_W-1:0], in_valid_i};
      out_vld_q <= vld_q[QUO_W];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_drive_o  = drive_q[0];
  assign right_drive_o = drive_q[1];
  assign is_armed_o    = armed_out_q;
  assign speed_mode_o  = mode_out_q;

endmodule

// ===== sv/rcdm_checker.sv =====
// Port-level checks for the differential drive mixer, bound to the top level.
// Depends on rcdm_pkg and rc_differential_drive_mixer.
module rcdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import rcdm_pkg::*;

  // Hold a stalled result
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A disarmed result drives both wheels to zero
  a_disarmed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("disarmed result with nonzero drive");

  // Speed mode is one of the three modes
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2:1] == SPEED_SLOW ||
                       m_axis_tuser[2:1] == SPEED_MEDIUM ||
                       m_axis_tuser[2:1] == SPEED_FAST))
    else $error("speed mode code out of range");

  // Drive commands stay within plus or minus one in Q14
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[15:0]) >= -16'sd16384 &&
      $signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
      $signed(m_axis_tdata[31:16]) >= -16'sd16384 &&
      $signed(m_axis_tdata[31:16]) <= 16'sd16384)
    else $error("drive command out of range");

endmodule

bind rc_differential_drive_mixer rcdm_checker u_rcdm_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for rc_differential_drive_mixer: drives raw channel items and
// register writes, predicts every drive command and compares it with the block.
// Depends on rcdm_pkg and the rc_differential_drive_mixer RTL.
`timescale 1ns / 100ps

module testbench;
  import rcdm_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 40;     // comfortably above the block's input-to-result latency
  localparam int IDLE_PCT     = 13;
  localparam int MAX_PRINTS   = 40;

  localparam int RAW_CENTRE = 992;
  localparam int RAW_SPAN   = 819;
  localparam int RAW_MAX    = 2047;
  localparam int Q14_FULL   = 16384;

  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  // Raw channel values for the directed items
  localparam logic [10:0] RAW_ZERO  = 11'd0;
  localparam logic [10:0] RAW_MID   = 11'd992;
  localparam logic [10:0] RAW_TOP   = 11'd2047;
  localparam logic [10:0] RAW_MID_UP = 11'd993;
  localparam logic [10:0] RAW_MID_DN = 11'd991;

  // Raw values either side of the default thresholds (+-0.5 in Q14)
  localparam logic [10:0] RAW_BELOW_HALF  = 11'd1401;  // 8181
  localparam logic [10:0] RAW_ABOVE_HALF  = 11'd1402;  // 8202
  localparam logic [10:0] RAW_ABOVE_NHALF = 11'd583;   // -8181
  localparam logic [10:0] RAW_BELOW_NHALF = 11'd582;   // -8202
  localparam logic [10:0] RAW_FULL_POS    = 11'd1811;  // exactly +1.0
  localparam logic [10:0] RAW_FULL_NEG    = 11'd173;   // exactly -1.0
  localparam logic [10:0] RAW_OVER_POS    = 11'd1812;  // just past +1.0
  localparam logic [10:0] RAW_OVER_NEG    = 11'd172;   // just past -1.0

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        armed;
    speed_mode_e mode;
  } drive_result_t;

  // Holds the register copy, predicts one drive command per accepted item and
  // matches block results against the oldest outstanding prediction.
  class mixer_scoreboard;
    logic signed [15:0] arm_thr, low_thr, high_thr;
    logic [14:0]        slow_scl, med_scl, fast_scl;
    drive_result_t      awaited[$];
    int errors, items, results, writes, armed_hits, lost_hits;
    int mode_hits[3];

    function new();
      arm_thr  = 16'sd8192;
      low_thr  = -16'sd8192;
      high_thr = 16'sd8192;
      slow_scl = 15'd5461;
      med_scl  = 15'd10923;
      fast_scl = 15'd16384;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] val);
      writes++;
      case (idx)
        CFG_ARM_THR:        arm_thr  = val;
        CFG_SPEED_LOW_THR:  low_thr  = val;
        CFG_SPEED_HIGH_THR: high_thr = val;
        CFG_SLOW_SCALE:     slow_scl = val[14:0];
        CFG_MEDIUM_SCALE:   med_scl  = val[14:0];
        CFG_FAST_SCALE:     fast_scl = val[14:0];
        default: ;
      endcase
    endfunction

    // (v - 992) / 819 in Q14, truncated toward zero, clamped to +-1.0
    function int normalise(logic [10:0] raw);
      int q;
      q = ((int'(raw) - RAW_CENTRE) * Q14_FULL) / RAW_SPAN;
      if (q > Q14_FULL) q = Q14_FULL;
      if (q < -Q14_FULL) q = -Q14_FULL;
      return q;
    endfunction

    function void note_input(logic [47:0] d, logic lost);
      drive_result_t want;
      int thr, stk, arm, spd, lo, hi, at, scl, sum, dif, peak, denom;
      longint lq, rq;
      thr = lost ? 0 : normalise(d[10:0]);
      stk = lost ? 0 : normalise(d[21:11]);
      arm = lost ? 0 : normalise(d[32:22]);
      spd = lost ? 0 : normalise(d[43:33]);
      lo = low_thr;
      hi = high_thr;
      at = arm_thr;
      // slow test first, so overlapping thresholds favour slow
      if (spd < lo) begin
        want.mode = SPEED_SLOW;
        scl = slow_scl;
      end else if (spd > hi) begin
        want.mode = SPEED_FAST;
        scl = fast_scl;
      end else begin
        want.mode = SPEED_MEDIUM;
        scl = med_scl;
      end
      if (scl > Q14_FULL) scl = Q14_FULL;
      want.armed = !lost && (arm > at);
      lq = 0;
      rq = 0;
      if (want.armed) begin
        sum   = thr + stk;
        dif   = thr - stk;
        peak  = (sum < 0 ? -sum : sum) > (dif < 0 ? -dif : dif) ?
                (sum < 0 ? -sum : sum) : (dif < 0 ? -dif : dif);
        denom = peak > Q14_FULL ? peak : Q14_FULL;
        lq = (longint'(sum) * scl) / denom;
        rq = (longint'(dif) * scl) / denom;
      end
      want.left  = lq[15:0];
      want.right = rq[15:0];
      awaited.push_back(want);
      items++;
      if (want.armed) armed_hits++;
      if (lost) lost_hits++;
      mode_hits[want.mode]++;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] ERROR %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] d, logic [2:0] u);
      drive_result_t want;
      results++;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing outstanding: tdata=%h tuser=%h", d, u));
        return;
      end
      want = awaited.pop_front();
      if (d[15:0] !== want.left)
        report($sformatf("result %0d left_drive %h, want %h", results, d[15:0], want.left));
      if (d[31:16] !== want.right)
        report($sformatf("result %0d right_drive %h, want %h", results, d[31:16],
                         want.right));
      if (u[0] !== want.armed)
        report($sformatf("result %0d is_armed %b, want %b", results, u[0], want.armed));
      if (u[2:1] !== want.mode)
        report($sformatf("result %0d speed_mode %0d, want %0d", results, u[2:1],
                         want.mode));
    endtask
  endclass

  // Every input starts at a known value; reset is held low from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  mixer_scoreboard sb;
  bit  no_stall = 1'b0;   // set for the stretch where neither side idles
  int  cycle_count = 0;
  int  phases = 0;
  int  arm_pivot = RAW_CENTRE, low_pivot = RAW_CENTRE, high_pivot = RAW_CENTRE;

  rc_differential_drive_mixer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Abort a hung run; the limit is many times the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending());
      $display("rc_differential_drive_mixer: mismatch");
      $finish;
    end
  end

  // Monitors sample the values that stood before the edge, so the bench's own
  // nonblocking drives in the same step never leak into what is observed.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tdata, s_axis_tuser[0]);
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.set_register(cfg_index_i, cfg_data_i);
  end

  // Result side: check each accepted item, then draw the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Present one item and hold it until the block takes it. Valid is left high
  // so the next item can follow in the very next cycle.
  task automatic send_item(input logic [10:0] thr, stk, arm, spd, input logic lost);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, spd, arm, stk, thr};
    s_axis_tuser  <= lost;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_input(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all six registers plus both spare indexes, then drop valid
  task automatic load_settings(input logic [15:0] arm_v, lo_v, hi_v, slow_v, med_v,
                               fast_v);
    write_reg(CFG_ARM_THR, arm_v);
    write_reg(CFG_SPEED_LOW_THR, lo_v);
    write_reg(CFG_SPEED_HIGH_THR, hi_v);
    write_reg(CFG_SLOW_SCALE, slow_v);
    write_reg(CFG_MEDIUM_SCALE, med_v);
    write_reg(CFG_FAST_SCALE, fast_v);
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    cfg_valid_i <= 1'b0;
    phases++;
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Raw value biased towards the extremes, the centre and a chosen pivot
  function automatic logic [10:0] pick_raw(int pivot);
    int r, v;
    r = $urandom_range(99);
    if (r < 10)      v = $urandom_range(1) ? RAW_MAX : 0;
    else if (r < 20) v = RAW_CENTRE - 1 + $urandom_range(2);
    else if (r < 35) v = pivot - 1 + $urandom_range(2);
    else             v = $urandom_range(RAW_MAX);
    return v[10:0];
  endfunction

  function automatic logic [15:0] rand_threshold();
    if ($urandom_range(99) < 85) return 16'($urandom_range(2 * Q14_FULL) - Q14_FULL);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_scale();
    if ($urandom_range(99) < 80) return 16'($urandom_range(Q14_FULL));
    return 16'($urandom);
  endfunction

  task automatic randomise_settings();
    arm_pivot  = $urandom_range(RAW_MAX - 1, 1);
    low_pivot  = $urandom_range(RAW_MAX - 1, 1);
    high_pivot = $urandom_range(RAW_MAX - 1, 1);
    // mostly land thresholds on reachable levels so the strict compares are hit
    load_settings(
      $urandom_range(99) < 70 ? 16'(sb.normalise(arm_pivot)) : rand_threshold(),
      $urandom_range(99) < 70 ? 16'(sb.normalise(low_pivot)) : rand_threshold(),
      $urandom_range(99) < 70 ? 16'(sb.normalise(high_pivot)) : rand_threshold(),
      rand_scale(), rand_scale(), rand_scale());
  endtask

  // Random items: mostly armed so the mixer path is exercised, some failsafe
  task automatic send_random(input int count);
    logic [10:0] arm;
    for (int n = 0; n < count; n++) begin
      if (!no_stall && $urandom_range(99) < IDLE_PCT) pause_input(1);
      arm = ($urandom_range(99) < 50) ? 11'($urandom_range(RAW_MAX, 1300))
                                      : pick_raw(arm_pivot);
      send_item(pick_raw($urandom_range(RAW_MAX - 1, 1)),
                pick_raw($urandom_range(RAW_MAX - 1, 1)), arm,
                pick_raw($urandom_range(1) ? low_pivot : high_pivot),
                $urandom_range(99) < 8);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset settings
    send_item(RAW_MID, RAW_MID, RAW_TOP, RAW_MID, 1'b0);            // centred sticks
    send_item(RAW_TOP, RAW_MID, RAW_TOP, RAW_MID, 1'b0);            // full forward
    send_item(RAW_ZERO, RAW_MID, RAW_TOP, RAW_MID, 1'b0);           // full reverse
    send_item(RAW_MID, RAW_TOP, RAW_TOP, RAW_MID, 1'b0);            // spin on the spot
    send_item(RAW_TOP, RAW_TOP, RAW_TOP, RAW_MID, 1'b0);            // peak above 1.0
    send_item(RAW_ZERO, RAW_ZERO, RAW_TOP, RAW_MID, 1'b0);
    send_item(RAW_TOP, RAW_ZERO, RAW_TOP, RAW_MID, 1'b0);
    send_item(RAW_ZERO, RAW_TOP, RAW_TOP, RAW_MID, 1'b0);
    send_item(RAW_TOP, RAW_MID, RAW_TOP, RAW_ZERO, 1'b0);           // slow mode
    send_item(RAW_TOP, RAW_MID, RAW_TOP, RAW_TOP, 1'b0);            // fast mode
    send_item(RAW_TOP, RAW_ZERO, RAW_BELOW_HALF, RAW_TOP, 1'b0);    // just short of arming
    send_item(RAW_TOP, RAW_ZERO, RAW_ABOVE_HALF, RAW_TOP, 1'b0);    // just armed
    send_item(RAW_TOP, RAW_ZERO, RAW_TOP, RAW_ZERO, 1'b1);          // failsafe
    send_item(RAW_TOP, RAW_TOP, RAW_TOP, RAW_TOP, 1'b1);
    send_item(RAW_TOP, RAW_TOP, RAW_ZERO, RAW_ZERO, 1'b0);          // disarmed, slow
    send_item(RAW_ZERO, RAW_ZERO, RAW_ZERO, RAW_ZERO, 1'b0);
    send_item(RAW_TOP, RAW_TOP, RAW_TOP, RAW_TOP, 1'b0);
    send_item(RAW_MID_UP, RAW_MID_DN, RAW_TOP, RAW_MID, 1'b0);
    send_item(RAW_FULL_POS, RAW_FULL_NEG, RAW_TOP, RAW_MID, 1'b0);
    send_item(RAW_OVER_POS, RAW_OVER_NEG, RAW_TOP, RAW_MID, 1'b0);  // clamped
    send_item(RAW_TOP, RAW_MID, RAW_TOP, RAW_BELOW_HALF, 1'b0);     // medium edge
    send_item(RAW_TOP, RAW_MID, RAW_TOP, RAW_ABOVE_HALF, 1'b0);     // fast edge
    send_item(RAW_ZERO, RAW_MID, RAW_TOP, RAW_ABOVE_NHALF, 1'b0);   // medium edge
    send_item(RAW_ZERO, RAW_MID, RAW_TOP, RAW_BELOW_NHALF, 1'b0);   // slow edge
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Lowest thresholds, zero scales: nearly always armed, never slow
    load_settings(-16'sd16384, -16'sd16384, 16'sd16384, 16'd0, 16'd0, 16'd0);
    send_random(150);
    wait_drained();

    // Arm threshold at +1.0 can never arm; speed thresholds overlap fully
    load_settings(16'sd16384, 16'sd16384, -16'sd16384, 16'd16384, 16'd16384,
                  16'd16384);
    send_random(100);
    wait_drained();

    // Thresholds beyond the Q14 range and scales above 1.0 that must saturate
    load_settings(16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'h7fff, 16'h4001);
    send_random(150);
    wait_drained();

    // Back to the defaults with both sides running flat out
    load_settings(16'sd8192, -16'sd8192, 16'sd8192, 16'd5461, 16'd10923, 16'd16384);
    no_stall = 1'b1;
    send_random(200);
    wait_drained();
    no_stall = 1'b0;

    repeat (4) begin
      randomise_settings();
      send_random(200);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d items over %0d register settings (%0d writes), %0d results",
             sb.items, phases + 1, sb.writes, sb.results);
    $display("%0d armed, %0d in failsafe; speed modes slow/medium/fast %0d/%0d/%0d",
             sb.armed_hits, sb.lost_hits, sb.mode_hits[SPEED_SLOW],
             sb.mode_hits[SPEED_MEDIUM], sb.mode_hits[SPEED_FAST]);
    if (sb.errors == 0) begin
      $display("rc_differential_drive_mixer: match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("rc_differential_drive_mixer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rcdm_pkg.sv
sv/rcdm_front.sv
sv/rcdm_queue.sv
sv/rcdm_back.sv
sv/rc_differential_drive_mixer.sv
sv/rcdm_checker.sv
tb/sv/testbench.sv
